FILE: design/i2cm_pkg.sv
// Shared types, state encoding and constants for the I2C register access master.
// Used by i2cm_core and i2c_master_register_access; depends on nothing.
package i2cm_pkg;

    localparam int DELAY_BITS = 16;
    localparam int PHASE_W    = 16;
    localparam logic [PHASE_W-1:0] PHASE_RESET = 16'd160;

    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    localparam logic [1:0] ROLE_ADDR  = 2'd0;
    localparam logic [1:0] ROLE_REG   = 2'd1;
    localparam logic [1:0] ROLE_DATA  = 2'd2;
    localparam logic [1:0] ROLE_RADDR = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_SDA_LOW   = 3'd1;
    localparam logic [2:0] ST_SDA_HIGH  = 3'd2;
    localparam logic [2:0] ST_ADDR_NACK = 3'd3;
    localparam logic [2:0] ST_REG_NACK  = 3'd4;
    localparam logic [2:0] ST_DATA_NACK = 3'd5;

    typedef enum logic [4:0] {
        S_IDLE    = 5'd0,
        S_ST_SDAH = 5'd1,
        S_ST_SCLH = 5'd2,
        S_ST_SDAL = 5'd3,
        S_ST_SCLL = 5'd4,
        S_TX_LOW  = 5'd5,
        S_TX_DATA = 5'd6,
        S_TX_HIGH = 5'd7,
        S_ACK_LOW = 5'd8,
        S_ACK_REL = 5'd9,
        S_ACK_HIGH = 5'd10,
        S_RX_LOW  = 5'd11,
        S_RX_HIGH = 5'd12,
        S_MA_LOW  = 5'd13,
        S_MA_DATA = 5'd14,
        S_MA_HIGH = 5'd15,
        S_MA_END  = 5'd16,
        S_SP_SCLL = 5'd17,
        S_SP_SDAL = 5'd18,
        S_SP_SCLH = 5'd19,
        S_SP_SDAH = 5'd20
    } step_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [6:0] dev_addr;
        logic [7:0] reg_addr;
        logic [7:0] length;
        logic [7:0] write_byte;
        logic       sda_in;
    } item_t;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       byte_taken;
        logic [7:0] read_byte;
        logic       read_valid;
        logic       read_last;
        logic       busy_res;
        logic       done_res;
        logic [2:0] status;
    } res_t;

endpackage

FILE: design/i2cm_core.sv
// Bus sequencer of the I2C register access master: state registers and one tick of logic.
// Depends on i2cm_pkg.
module i2cm_core
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  i2cm_pkg::item_t                      item,
    input  logic [i2cm_pkg::PHASE_W-1:0]         phase_ticks,
    output i2cm_pkg::res_t                       res
);
    import i2cm_pkg::*;

    step_t                 step_reg, step_next, target;
    logic [DELAY_BITS-1:0] phase_cnt_reg, phase_cnt_next;
    logic [3:0]            bit_cnt_reg, bit_cnt_next;
    logic [7:0]            shreg_reg, shreg_next;
    logic [7:0]            bytes_left_reg, bytes_left_next;
    logic [6:0]            saved_dev_reg, saved_dev_next;
    logic [7:0]            saved_reg_reg, saved_reg_next;
    logic                  read_dir_reg, read_dir_next;
    logic [1:0]            role_reg, role_next;
    logic [2:0]            pending_reg, pending_next;
    logic                  scl_q_reg, scl_q_next;
    logic                  sda_q_reg, sda_q_next;

    logic [PHASE_W-1:0]    limit;
    logic [32:0]           pc_inc;
    logic                  go;
    logic                  taken, rvalid, rlast, done;
    logic [7:0]            rbyte;
    logic [2:0]            code;

    assign limit  = (phase_ticks == '0) ? PHASE_W'(1) : phase_ticks;
    assign pc_inc = 33'(phase_cnt_reg) + 33'd1;

    always_comb
    begin
        step_next       = step_reg;
        phase_cnt_next  = phase_cnt_reg;
        bit_cnt_next    = bit_cnt_reg;
        shreg_next      = shreg_reg;
        bytes_left_next = bytes_left_reg;
        saved_dev_next  = saved_dev_reg;
        saved_reg_next  = saved_reg_reg;
        read_dir_next   = read_dir_reg;
        role_next       = role_reg;
        pending_next    = pending_reg;
        scl_q_next      = scl_q_reg;
        sda_q_next      = sda_q_reg;
        go              = 1'b0;
        target          = S_IDLE;
        taken           = 1'b0;
        rvalid          = 1'b0;
        rlast           = 1'b0;
        rbyte           = 8'd0;
        done            = 1'b0;
        code            = ST_OK;

        if (step_reg == S_IDLE)
        begin
            if (item.kind == KIND_WRITE || item.kind == KIND_READ)
            begin
                saved_dev_next  = item.dev_addr;
                saved_reg_next  = item.reg_addr;
                bytes_left_next = (item.length == 8'd0) ? 8'd1 : item.length;
                read_dir_next   = (item.kind == KIND_READ);
                role_next       = ROLE_ADDR;
                pending_next    = ST_OK;
                bit_cnt_next    = 4'd0;
                go              = 1'b1;
                target          = S_ST_SDAH;
            end
        end
        else if (pc_inc < 33'(limit) && phase_cnt_reg != '1)
        begin
            phase_cnt_next = phase_cnt_reg + DELAY_BITS'(1);
        end
        else
        begin
            go = 1'b1;
            case (step_reg)
                S_ST_SDAH: target = S_ST_SCLH;
                S_ST_SCLH:
                begin
                    if (!item.sda_in)
                    begin
                        code   = ST_SDA_LOW;
                        done   = 1'b1;
                        target = S_IDLE;
                    end
                    else
                        target = S_ST_SDAL;
                end
                S_ST_SDAL:
                begin
                    if (item.sda_in)
                    begin
                        code   = ST_SDA_HIGH;
                        done   = 1'b1;
                        target = S_IDLE;
                    end
                    else
                        target = S_ST_SCLL;
                end
                S_ST_SCLL:
                begin
                    shreg_next   = {saved_dev_reg, (role_reg == ROLE_RADDR)};
                    bit_cnt_next = 4'd0;
                    target       = S_TX_LOW;
                end
                S_TX_LOW:  target = S_TX_DATA;
                S_TX_DATA: target = S_TX_HIGH;
                S_TX_HIGH:
                begin
                    shreg_next   = {shreg_reg[6:0], 1'b0};
                    bit_cnt_next = bit_cnt_reg + 4'd1;
                    target       = (bit_cnt_next >= 4'd8) ? S_ACK_LOW : S_TX_LOW;
                end
                S_ACK_LOW: target = S_ACK_REL;
                S_ACK_REL: target = S_ACK_HIGH;
                S_ACK_HIGH:
                begin
                    scl_q_next   = 1'b0;
                    bit_cnt_next = 4'd0;
                    if (item.sda_in)
                    begin
                        pending_next = (role_reg == ROLE_REG)  ? ST_REG_NACK :
                                       (role_reg == ROLE_DATA) ? ST_DATA_NACK : ST_ADDR_NACK;
                        target       = S_SP_SCLL;
                    end
                    else
                    begin
                        case (role_reg)
                            ROLE_ADDR:
                            begin
                                role_next  = ROLE_REG;
                                shreg_next = saved_reg_reg;
                                target     = S_TX_LOW;
                            end
                            ROLE_REG:
                            begin
                                if (read_dir_reg)
                                begin
                                    role_next = ROLE_RADDR;
                                    target    = S_ST_SDAH;
                                end
                                else
                                begin
                                    role_next  = ROLE_DATA;
                                    shreg_next = item.write_byte;
                                    taken      = 1'b1;
                                    target     = S_TX_LOW;
                                end
                            end
                            ROLE_DATA:
                            begin
                                bytes_left_next = bytes_left_reg - 8'd1;
                                if (bytes_left_next == 8'd0)
                                begin
                                    pending_next = ST_OK;
                                    target       = S_SP_SCLL;
                                end
                                else
                                begin
                                    shreg_next = item.write_byte;
                                    taken      = 1'b1;
                                    target     = S_TX_LOW;
                                end
                            end
                            default:
                            begin
                                shreg_next = 8'd0;
                                target     = S_RX_LOW;
                            end
                        endcase
                    end
                end
                S_RX_LOW:  target = S_RX_HIGH;
                S_RX_HIGH:
                begin
                    shreg_next   = {shreg_reg[6:0], item.sda_in};
                    bit_cnt_next = bit_cnt_reg + 4'd1;
                    if (bit_cnt_next >= 4'd8)
                    begin
                        rvalid = 1'b1;
                        rbyte  = shreg_next;
                        rlast  = (bytes_left_reg == 8'd1);
                        target = S_MA_LOW;
                    end
                    else
                        target = S_RX_LOW;
                end
                S_MA_LOW:  target = S_MA_DATA;
                S_MA_DATA: target = S_MA_HIGH;
                S_MA_HIGH: target = S_MA_END;
                S_MA_END:
                begin
                    bytes_left_next = bytes_left_reg - 8'd1;
                    if (bytes_left_next == 8'd0)
                    begin
                        pending_next = ST_OK;
                        target       = S_SP_SCLL;
                    end
                    else
                    begin
                        bit_cnt_next = 4'd0;
                        shreg_next   = 8'd0;
                        target       = S_RX_LOW;
                    end
                end
                S_SP_SCLL: target = S_SP_SDAL;
                S_SP_SDAL: target = S_SP_SCLH;
                S_SP_SCLH: target = S_SP_SDAH;
                S_SP_SDAH:
                begin
                    code   = pending_reg;
                    done   = 1'b1;
                    target = S_IDLE;
                end
                default:   target = S_IDLE;
            endcase
        end

        // enter the next phase and set the line drives it calls for
        if (go)
        begin
            step_next      = target;
            phase_cnt_next = '0;
            case (target)
                S_ST_SDAH: sda_q_next = 1'b1;
                S_ST_SCLH: scl_q_next = 1'b1;
                S_ST_SDAL: sda_q_next = 1'b0;
                S_ST_SCLL: scl_q_next = 1'b0;
                S_TX_LOW:  scl_q_next = 1'b0;
                S_TX_DATA: sda_q_next = shreg_next[7];
                S_TX_HIGH: scl_q_next = 1'b1;
                S_ACK_LOW: scl_q_next = 1'b0;
                S_ACK_REL: sda_q_next = 1'b1;
                S_ACK_HIGH: scl_q_next = 1'b1;
                S_RX_LOW:
                begin
                    scl_q_next = 1'b0;
                    sda_q_next = 1'b1;
                end
                S_RX_HIGH: scl_q_next = 1'b1;
                S_MA_LOW:  scl_q_next = 1'b0;
                S_MA_DATA: sda_q_next = (bytes_left_next == 8'd1);
                S_MA_HIGH: scl_q_next = 1'b1;
                S_MA_END:  scl_q_next = 1'b0;
                S_SP_SCLL: scl_q_next = 1'b0;
                S_SP_SDAL: sda_q_next = 1'b0;
                S_SP_SCLH: scl_q_next = 1'b1;
                S_SP_SDAH: sda_q_next = 1'b1;
                default:
                begin
                    scl_q_next = 1'b1;
                    sda_q_next = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg       <= S_IDLE;
            phase_cnt_reg  <= '0;
            bit_cnt_reg    <= 4'd0;
            shreg_reg      <= 8'd0;
            bytes_left_reg <= 8'd0;
            saved_dev_reg  <= 7'd0;
            saved_reg_reg  <= 8'd0;
            read_dir_reg   <= 1'b0;
            role_reg       <= ROLE_ADDR;
            pending_reg    <= ST_OK;
            scl_q_reg      <= 1'b1;
            sda_q_reg      <= 1'b1;
        end
        else if (en)
        begin
            step_reg       <= step_next;
            phase_cnt_reg  <= phase_cnt_next;
            bit_cnt_reg    <= bit_cnt_next;
            shreg_reg      <= shreg_next;
            bytes_left_reg <= bytes_left_next;
            saved_dev_reg  <= saved_dev_next;
            saved_reg_reg  <= saved_reg_next;
            read_dir_reg   <= read_dir_next;
            role_reg       <= role_next;
            pending_reg    <= pending_next;
            scl_q_reg      <= scl_q_next;
            sda_q_reg      <= sda_q_next;
        end
    end

    assign res.scl_out    = scl_q_reg;
    assign res.sda_out    = sda_q_reg;
    assign res.byte_taken = taken;
    assign res.read_byte  = rbyte;
    assign res.read_valid = rvalid;
    assign res.read_last  = rlast;
    assign res.busy_res   = (step_next != S_IDLE);
    assign res.done_res   = done;
    assign res.status     = code;

endmodule

FILE: design/i2c_master_register_access.sv
// Top level of the I2C register access master: input register, sequencer, result register.
// Depends on i2cm_pkg and i2cm_core.
//
// Each input word is one tick of the bus timing. A tick of kind 1 or 2 seen while idle
// starts a burst write or read to dev_addr at reg_addr for length bytes; every SCL/SDA
// phase lasts phase_ticks ticks (reset 160), set through cfg_we/cfg_wdata; the user must
// write it only while idle, the block does not enforce that. Every input word yields exactly
// one result word with the line drives for that tick, write-byte and read-byte strobes,
// busy, and done with status when a transfer ends. m_tlast marks the last received byte
// of a read burst. An accepted word waits in the input register and is handled by the
// sequencer as it is written into the result register that drives m_*.
// One word per cycle is taken and delivered while the receiver does not stall;
// the rate is set by the single tick of the sequencer between the input register and
// the result register. When the receiver stalls, the result register and then the input
// register hold their words and s_tready falls; nothing is dropped.
// Reset empties both registers, returns the sequencer to idle with both lines released
// and loads phase_ticks with 160.
module i2c_master_register_access
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,     // phase_ticks
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,       // dev_addr, reg_addr, length, write_byte, sda_in
    input  logic [1:0]  s_tuser,       // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,       // scl_out, sda_out, byte_taken, read_byte,
                                       // read_valid, busy_res, done_res, status, zero pad
    output logic        m_tlast        // read_last
);
    import i2cm_pkg::*;

    logic [PHASE_W-1:0] phase_ticks_reg;
    logic               in_vld_reg;
    logic [31:0]        in_data_reg;
    logic [1:0]         in_kind_reg;
    logic               out_vld_reg;
    res_t               out_res_reg;
    logic               advance;
    item_t              item;
    res_t               res;

    assign advance  = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || advance;

    assign item.kind       = in_kind_reg;
    assign item.dev_addr   = in_data_reg[6:0];
    assign item.reg_addr   = in_data_reg[14:7];
    assign item.length     = in_data_reg[22:15];
    assign item.write_byte = in_data_reg[30:23];
    assign item.sda_in     = in_data_reg[31];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_ticks_reg <= PHASE_RESET;
        else if (cfg_we)
            phase_ticks_reg <= cfg_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (s_tready)
            in_vld_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_data_reg <= s_tdata;
            in_kind_reg <= s_tuser;
        end
    end

    i2cm_core u_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (advance),
        .item        (item),
        .phase_ticks (phase_ticks_reg),
        .res         (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (advance)
            out_vld_reg <= 1'b1;
        else if (m_tready)
            out_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_res_reg <= res;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tlast  = out_res_reg.read_last;
    assign m_tdata  = {7'd0, out_res_reg.status, out_res_reg.done_res, out_res_reg.busy_res,
                       out_res_reg.read_valid, out_res_reg.read_byte,
                       out_res_reg.byte_taken, out_res_reg.sda_out, out_res_reg.scl_out};

`ifndef SYNTHESIS
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_vld_reg |-> s_tready)
        else $error("input register empty but not ready");

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && !m_tready |=> out_vld_reg && $stable(out_res_reg))
        else $error("stalled result word lost or changed");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[13] |-> !m_tdata[12])
        else $error("done reported while still busy");

    a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tdata[11] && !m_tdata[2])
        else $error("last flag without a received byte");
`endif

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// Testbench for i2c_master_register_access: a scripted bus slave answers on sda_in while a
// cycle-true master model predicts every result word. Depends on i2cm_pkg and the design.
module tb;
    import i2cm_pkg::*;

    localparam int WATCHDOG  = 3000;
    localparam int LONG_HOLD = 400;
    localparam logic [1:0] KIND_SPARE = 2'd3;

    typedef enum int {
        FLT_NONE,
        FLT_START_LOW,
        FLT_START_HIGH,
        FLT_RSTART_LOW,
        FLT_RSTART_HIGH,
        FLT_ADDR_NACK,
        FLT_REG_NACK,
        FLT_DATA_NACK,
        FLT_RADDR_NACK
    } fault_t;

    typedef struct packed {
        step_t       step;
        logic [15:0] cnt;
        logic [3:0]  bits;
        logic [7:0]  shreg;
        logic [7:0]  left;
        logic [6:0]  dev;
        logic [7:0]  regad;
        logic        rd;
        logic [1:0]  role;
        logic [2:0]  pend;
        logic        scl;
        logic        sda;
    } master_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tlast;

    item_t       tick_feed_q[$];
    res_t        line_state_q[$];
    item_t       cur;
    item_t       seen;
    res_t        want;
    res_t        got;

    master_t     gen_master;
    master_t     chk_master;
    logic [15:0] gen_ticks = PHASE_RESET;
    logic [15:0] chk_ticks = PHASE_RESET;
    fault_t      gen_fault = FLT_NONE;

    int          words_queued = 0;
    int          words_taken = 0;
    int          words_checked = 0;
    int          xfers_closed = 0;
    int          bytes_read = 0;
    logic [7:0]  codes_seen = '0;
    int          err_cnt = 0;
    int          quiet = 0;
    logic        s_fire = 1'b0;

    int          send_gap_pct = 0;
    int          recv_stall_pct = 0;
    logic        hold_req = 1'b0;
    logic        hold_done = 1'b0;
    int          hold_left = 0;

    i2c_master_register_access u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic master_t master_idle();
        master_t b;
        b = '0;
        b.step = S_IDLE;
        b.scl = 1'b1;
        b.sda = 1'b1;
        return b;
    endfunction

    function automatic void goto_step(inout master_t b, input step_t s);
        b.step = s;
        b.cnt = '0;
        case (s)
            S_ST_SDAH, S_ACK_REL, S_SP_SDAH:
                b.sda = 1'b1;
            S_ST_SCLH, S_TX_HIGH, S_ACK_HIGH, S_RX_HIGH, S_MA_HIGH, S_SP_SCLH:
                b.scl = 1'b1;
            S_ST_SDAL, S_SP_SDAL:
                b.sda = 1'b0;
            S_ST_SCLL, S_TX_LOW, S_ACK_LOW, S_MA_LOW, S_MA_END, S_SP_SCLL:
                b.scl = 1'b0;
            S_TX_DATA:
                b.sda = b.shreg[7];
            S_RX_LOW:
            begin
                b.scl = 1'b0;
                b.sda = 1'b1;
            end
            S_MA_DATA:
                b.sda = (b.left == 8'd1);
            default:
            begin
                b.step = S_IDLE;
                b.scl = 1'b1;
                b.sda = 1'b1;
            end
        endcase
    endfunction

    function automatic logic phase_ends(input master_t b, input logic [15:0] ticks);
        logic [15:0] lim;
        lim = (ticks == 16'd0) ? 16'd1 : ticks;
        return b.step != S_IDLE
            && !(({1'b0, b.cnt} + 17'd1 < {1'b0, lim}) && b.cnt != 16'hFFFF);
    endfunction

    function automatic res_t master_tick(inout master_t b, input item_t it,
                                         input logic [15:0] ticks);
        res_t r;
        r = '0;
        r.scl_out = b.scl;
        r.sda_out = b.sda;
        if (b.step == S_IDLE)
        begin
            if (it.kind == KIND_WRITE || it.kind == KIND_READ)
            begin
                b.dev = it.dev_addr;
                b.regad = it.reg_addr;
                b.left = (it.length == 8'd0) ? 8'd1 : it.length;
                b.rd = (it.kind == KIND_READ);
                b.role = ROLE_ADDR;
                b.pend = ST_OK;
                b.bits = '0;
                goto_step(b, S_ST_SDAH);
            end
        end
        else if (!phase_ends(b, ticks))
            b.cnt = b.cnt + 16'd1;
        else
        begin
            case (b.step)
                S_ST_SCLH:
                begin
                    if (!it.sda_in)
                    begin
                        r.status = ST_SDA_LOW;
                        r.done_res = 1'b1;
                        goto_step(b, S_IDLE);
                    end
                    else
                        goto_step(b, S_ST_SDAL);
                end
                S_ST_SDAL:
                begin
                    if (it.sda_in)
                    begin
                        r.status = ST_SDA_HIGH;
                        r.done_res = 1'b1;
                        goto_step(b, S_IDLE);
                    end
                    else
                        goto_step(b, S_ST_SCLL);
                end
                S_ST_SCLL:
                begin
                    b.shreg = {b.dev, b.role == ROLE_RADDR};
                    b.bits = '0;
                    goto_step(b, S_TX_LOW);
                end
                S_TX_HIGH:
                begin
                    b.shreg = {b.shreg[6:0], 1'b0};
                    b.bits = b.bits + 4'd1;
                    goto_step(b, (b.bits >= 4'd8) ? S_ACK_LOW : S_TX_LOW);
                end
                S_ACK_HIGH:
                begin
                    b.scl = 1'b0;
                    b.bits = '0;
                    if (it.sda_in)
                    begin
                        b.pend = (b.role == ROLE_REG) ? ST_REG_NACK :
                                 (b.role == ROLE_DATA) ? ST_DATA_NACK : ST_ADDR_NACK;
                        goto_step(b, S_SP_SCLL);
                    end
                    else if (b.role == ROLE_ADDR)
                    begin
                        b.role = ROLE_REG;
                        b.shreg = b.regad;
                        goto_step(b, S_TX_LOW);
                    end
                    else if (b.role == ROLE_REG && b.rd)
                    begin
                        b.role = ROLE_RADDR;
                        goto_step(b, S_ST_SDAH);
                    end
                    else if (b.role == ROLE_REG)
                    begin
                        b.role = ROLE_DATA;
                        b.shreg = it.write_byte;
                        r.byte_taken = 1'b1;
                        goto_step(b, S_TX_LOW);
                    end
                    else if (b.role == ROLE_DATA)
                    begin
                        b.left = b.left - 8'd1;
                        if (b.left == 8'd0)
                        begin
                            b.pend = ST_OK;
                            goto_step(b, S_SP_SCLL);
                        end
                        else
                        begin
                            b.shreg = it.write_byte;
                            r.byte_taken = 1'b1;
                            goto_step(b, S_TX_LOW);
                        end
                    end
                    else
                    begin
                        b.shreg = '0;
                        goto_step(b, S_RX_LOW);
                    end
                end
                S_RX_HIGH:
                begin
                    b.shreg = {b.shreg[6:0], it.sda_in};
                    b.bits = b.bits + 4'd1;
                    if (b.bits >= 4'd8)
                    begin
                        r.read_valid = 1'b1;
                        r.read_byte = b.shreg;
                        r.read_last = (b.left == 8'd1);
                        goto_step(b, S_MA_LOW);
                    end
                    else
                        goto_step(b, S_RX_LOW);
                end
                S_MA_END:
                begin
                    b.left = b.left - 8'd1;
                    if (b.left == 8'd0)
                    begin
                        b.pend = ST_OK;
                        goto_step(b, S_SP_SCLL);
                    end
                    else
                    begin
                        b.bits = '0;
                        b.shreg = '0;
                        goto_step(b, S_RX_LOW);
                    end
                end
                S_SP_SDAH:
                begin
                    r.status = b.pend;
                    r.done_res = 1'b1;
                    goto_step(b, S_IDLE);
                end
                default:
                    goto_step(b, step_t'(b.step + 5'd1));
            endcase
        end
        r.busy_res = (b.step != S_IDLE);
        return r;
    endfunction

    // slave reply at a sampled phase end: good start levels and ACKs unless a fault is armed, random bits otherwise
    function automatic logic slave_sda(input master_t b, input fault_t f);
        case (b.step)
            S_ST_SCLH:
                return (b.role == ROLE_RADDR) ? f != FLT_RSTART_LOW : f != FLT_START_LOW;
            S_ST_SDAL:
                return (b.role == ROLE_RADDR) ? f == FLT_RSTART_HIGH : f == FLT_START_HIGH;
            S_ACK_HIGH:
            begin
                if (b.role == ROLE_ADDR)
                    return f == FLT_ADDR_NACK;
                else if (b.role == ROLE_REG)
                    return f == FLT_REG_NACK;
                else if (b.role == ROLE_DATA)
                    return f == FLT_DATA_NACK && $urandom_range(1, 0) == 1;
                else
                    return f == FLT_RADDR_NACK;
            end
            default:
                return 1'($urandom_range(1, 0));
        endcase
    endfunction

    task automatic push_tick(input logic [1:0] kind, input logic [7:0] len);
        item_t it;
        it.kind = kind;
        it.dev_addr = 7'($urandom_range(127, 0));
        it.reg_addr = 8'($urandom_range(255, 0));
        it.length = len;
        it.write_byte = 8'($urandom_range(255, 0));
        it.sda_in = phase_ends(gen_master, gen_ticks) ? slave_sda(gen_master, gen_fault)
                                                     : 1'($urandom_range(1, 0));
        void'(master_tick(gen_master, it, gen_ticks));
        tick_feed_q.push_back(it);
        words_queued++;
    endtask

    task automatic run_xfer(input logic [1:0] kind, input int len, input fault_t f);
        logic [1:0] noise;
        gen_fault = f;
        push_tick(kind, 8'(len));
        while (gen_master.step != S_IDLE)
        begin
            case ($urandom_range(7, 0))
                0: noise = KIND_WRITE;
                1: noise = KIND_READ;
                2: noise = KIND_SPARE;
                default: noise = KIND_TICK;
            endcase
            push_tick(noise, 8'($urandom_range(255, 0)));
        end
    endtask

    task automatic random_xfers(input int words, input int max_len);
        int stop_at;
        int len;
        fault_t f;
        stop_at = words_queued + words;
        while (words_queued < stop_at)
        begin
            repeat ($urandom_range(3, 0))
                push_tick($urandom_range(1, 0) ? KIND_TICK : KIND_SPARE,
                          8'($urandom_range(255, 0)));
            len = ($urandom_range(9, 0) == 0) ? $urandom_range(max_len, 0)
                                              : $urandom_range(3, 1);
            f = ($urandom_range(4, 0) == 0) ? fault_t'($urandom_range(8, 1)) : FLT_NONE;
            run_xfer($urandom_range(1, 0) ? KIND_WRITE : KIND_READ, len, f);
        end
    endtask

    task automatic drain();
        @(negedge clk);
        while (words_taken != words_queued || line_state_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_ticks(input logic [15:0] v);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        gen_ticks = v;
        chk_ticks = v;
    endtask

    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || s_fire))
        begin
            if (tick_feed_q.size() != 0 && $urandom_range(99, 0) >= send_gap_pct)
            begin
                cur = tick_feed_q.pop_front();
                s_tdata <= {cur.sda_in, cur.write_byte, cur.length, cur.reg_addr, cur.dev_addr};
                s_tuser <= cur.kind;
                s_tvalid <= 1'b1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end
        else if (hold_req && !hold_done)
        begin
            hold_left <= LONG_HOLD;
            hold_done <= 1'b1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            s_fire <= s_tvalid && s_tready;
            if (s_tvalid && s_tready)
            begin
                seen.kind = s_tuser;
                seen.dev_addr = s_tdata[6:0];
                seen.reg_addr = s_tdata[14:7];
                seen.length = s_tdata[22:15];
                seen.write_byte = s_tdata[30:23];
                seen.sda_in = s_tdata[31];
                line_state_q.push_back(master_tick(chk_master, seen, chk_ticks));
                words_taken++;
            end
            if (m_tvalid && m_tready)
            begin
                got.scl_out = m_tdata[0];
                got.sda_out = m_tdata[1];
                got.byte_taken = m_tdata[2];
                got.read_byte = m_tdata[10:3];
                got.read_valid = m_tdata[11];
                got.busy_res = m_tdata[12];
                got.done_res = m_tdata[13];
                got.status = m_tdata[16:14];
                got.read_last = m_tlast;
                if (line_state_q.size() == 0)
                begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("unexpected result word %h last %b", m_tdata, m_tlast);
                end
                else
                begin
                    want = line_state_q.pop_front();
                    if (got !== want || m_tdata[23:17] !== '0)
                    begin
                        err_cnt++;
                        if (err_cnt <= 10)
                        begin
                            $display("mismatch at word %0d: expected scl %b sda %b taken %b %s",
                                     words_checked, want.scl_out, want.sda_out,
                                     want.byte_taken, "");
                            $display("  expected byte %h valid %b last %b busy %b done %b st %0d",
                                     want.read_byte, want.read_valid, want.read_last,
                                     want.busy_res, want.done_res, want.status);
                            $display("  got scl %b sda %b taken %b byte %h valid %b last %b",
                                     got.scl_out, got.sda_out, got.byte_taken, got.read_byte,
                                     got.read_valid, got.read_last);
                            $display("  got busy %b done %b st %0d pad %h",
                                     got.busy_res, got.done_res, got.status, m_tdata[23:17]);
                        end
                    end
                    if (want.done_res)
                    begin
                        xfers_closed++;
                        codes_seen[want.status] = 1'b1;
                    end
                    if (want.read_valid)
                        bytes_read++;
                end
                words_checked++;
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
            begin
                quiet++;
                if (quiet >= WATCHDOG)
                begin
                    $display("watchdog: no handshake for %0d cycles", WATCHDOG);
                    $display("FAILURE");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        gen_master = master_idle();
        chk_master = master_idle();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        run_xfer(KIND_READ, 2, FLT_START_LOW);
        drain();

        set_ticks(16'd1);
        run_xfer(KIND_WRITE, 0, FLT_NONE);
        run_xfer(KIND_READ, 1, FLT_NONE);
        for (int f = 1; f <= 8; f++)
        begin
            if (f == FLT_DATA_NACK)
                run_xfer(KIND_WRITE, 3, fault_t'(f));
            else
                run_xfer(KIND_READ, 1, fault_t'(f));
        end
        drain();

        set_ticks(16'd0);
        random_xfers(150, 4);
        drain();

        send_gap_pct = 69;
        set_ticks(16'd1);
        random_xfers(150, 4);
        drain();

        send_gap_pct = 0;
        recv_stall_pct = 69;
        set_ticks(16'd2);
        random_xfers(150, 4);
        drain();

        send_gap_pct = 26;
        recv_stall_pct = 26;
        set_ticks(16'd1);
        random_xfers(150, 4);
        drain();

        send_gap_pct = 0;
        recv_stall_pct = 0;
        set_ticks(16'd1);
        random_xfers(150, 4);
        hold_req = 1'b1;
        drain();
        repeat (8) @(posedge clk);

        $display("checked %0d tick words, %0d transfers closed, %0d bytes read back",
                 words_checked, xfers_closed, bytes_read);
        $display("status codes seen %b over phase lengths 160, 0, 1 and 2",
                 codes_seen[5:0]);
        if (err_cnt == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

FILE: sim.f
design/i2cm_pkg.sv
design/i2cm_core.sv
design/i2c_master_register_access.sv
tb/tb.sv
